/* hdl/wsre_pkg.sv */
// Shared types, widths and divider operation codes for the weighted spawn rate estimator.
// Used by every module of the block. No dependencies.
package wsre_pkg;

   // History depth: default and largest supported value.
   localparam int HISTORY_DEPTH_DEF = 8;
   localparam int HISTORY_DEPTH_MAX = 64;

   // Field widths.
   localparam int TIME_W  = 24;
   localparam int COUNT_W = 16;
   localparam int LIFE_W  = 32;
   localparam int OUT_W   = 32;

   // Working widths, sized for the largest history depth.
   localparam int SUM_W   = 30;   // sum of up to 63 Q8.16 intervals
   localparam int MEAN_W  = 24;
   localparam int WGT_W   = 41;   // 2^40 / interval sum
   localparam int WSUM_W  = 47;
   localparam int PROD_W  = 57;   // weight times a 16-bit operand
   localparam int RNUM_W  = 62;
   localparam int DNUM_W  = 79;

   // Shared divider geometry.
   localparam int DIV_REM_W  = 47;
   localparam int DIV_NUM_W  = 48;
   localparam int DIV_STEP_W = 6;

   // Divider operation codes.
   localparam logic [2:0] DIV_MEAN = 3'd0;
   localparam logic [2:0] DIV_WGT  = 3'd1;
   localparam logic [2:0] DIV_PER  = 3'd2;
   localparam logic [2:0] DIV_CNT  = 3'd3;
   localparam logic [2:0] DIV_LIFE = 3'd4;
   localparam logic [2:0] DIV_RATE = 3'd5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       take;
      logic       sum_init;
      logic       sum_step;
      logic       walk_init;
      logic       tsum_step;
      logic       div_start;
      logic       div_load;
      logic [2:0] div_op;
      logic       mul;
      logic       acc_step;
      logic       ladd;
      logic       vol;
      logic       out_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic held_lt2;
      logic k_last;
      logic div_done;
      logic wsum_zero;
      logic out_free;
   } dp_status_type;

endpackage

/* hdl/wsre_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on wsre_pkg for its widths.
module wsre_div
   import wsre_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIV_REM_W-1:0]  rem_init,
   input  logic [DIV_NUM_W-1:0]  num,
   input  logic [DIV_REM_W-1:0]  divisor,
   input  logic [DIV_STEP_W-1:0] steps,
   output logic [DIV_NUM_W-1:0]  quo,
   output logic                  done
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_STEP_W-1:0] cnt_ff;
   logic [DIV_REM_W-1:0]  rem_ff;
   logic [DIV_NUM_W-1:0]  num_ff;
   logic [DIV_NUM_W-1:0]  quo_ff;
   logic [DIV_REM_W-1:0]  dvs_ff;

   logic [DIV_REM_W:0]    shifted;
   logic [DIV_REM_W+1:0]  trial;

   // One trial subtraction of the divisor from the shifted remainder.
   always_comb begin
      shifted = {rem_ff, num_ff[DIV_NUM_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
   end

   // Control: busy while steps remain, done pulses after the last one.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == DIV_STEP_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == DIV_STEP_W'(1))) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Datapath: remainder, dividend bits and quotient shift together.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= rem_init;
         num_ff <= num;
         dvs_ff <= divisor;
         quo_ff <= '0;
         cnt_ff <= steps;
      end else if (busy_ff) begin
         if (!trial[DIV_REM_W+1]) begin
            rem_ff <= trial[DIV_REM_W-1:0];
            quo_ff <= {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[DIV_REM_W-1:0];
            quo_ff <= {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         num_ff <= {num_ff[DIV_NUM_W-2:0], 1'b0};
         cnt_ff <= cnt_ff - DIV_STEP_W'(1);
      end
   end

   assign quo  = quo_ff;
   assign done = done_ff;

   // A new division never starts over one in progress.
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");

   // Done follows the final step and the unit is then idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff)) else $error("divider done out of sequence");

endmodule

/* hdl/wsre_dp.sv */
// Datapath: sample history memories, accumulators, shared divider and result register.
// Depends on wsre_pkg and instantiates wsre_div.
module wsre_dp
   import wsre_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   input  logic [TIME_W-1:0]   req_delta_time,
   input  logic [COUNT_W-1:0]  req_spawned_count,
   input  logic [LIFE_W-1:0]   req_lifetime_total,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [OUT_W-1:0]    rsp_rate_estimate,
   output logic [OUT_W-1:0]    rsp_life_estimate,
   output logic [OUT_W-1:0]    rsp_volume_estimate
);

   localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int HW = $clog2(HISTORY_DEPTH + 1);
   localparam logic [PW-1:0] LAST_IDX = PW'(HISTORY_DEPTH - 1);
   localparam logic [HW-1:0] FULL     = HW'(HISTORY_DEPTH);

   // History memories; slot head_ff holds the newest sample.
   logic [TIME_W-1:0]         ivl_mem [HISTORY_DEPTH];
   logic [COUNT_W+LIFE_W-1:0] cl_mem  [HISTORY_DEPTH];
   logic [TIME_W-1:0]         ivl_rd_ff;
   logic [COUNT_W+LIFE_W-1:0] cl_rd_ff;

   logic [HW-1:0]     held_ff, held_in;
   logic [PW-1:0]     head_ff, head_in;
   logic [TIME_W-1:0] acc_ff, acc_in;
   logic              rsp_valid_ff;

   logic [PW-1:0]     ptr_ff;
   logic [HW-1:0]     k_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  tsum_ff;
   logic [MEAN_W-1:0] mean_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic [LIFE_W-1:0] lt_ff;
   logic [WGT_W-1:0]  w_ff;
   logic [LIFE_W-1:0] per_ff;
   logic [PROD_W-1:0] prod_r_ff, prod_h_ff, prod_l_ff;
   logic [WSUM_W-1:0] wsum_ff;
   logic [RNUM_W-1:0] rnum_ff, lhi_ff, llo_ff;
   logic [DNUM_W-1:0] dnum_ff;
   logic [OUT_W-1:0]  c_ff, life_ff, rate_ff, vol_ff;
   logic [OUT_W-1:0]  out_rate_ff, out_life_ff, out_vol_ff;

   logic [TIME_W:0]   acc_sum;
   logic [TIME_W-1:0] acc_sat;
   logic              push;
   logic [PW-1:0]     head_dec;
   logic [PW-1:0]     head_inc;
   logic [PW-1:0]     ptr_inc;
   logic [TIME_W-1:0] ivl_sel;
   logic [2*OUT_W-1:0] vol_prod;

   logic [DIV_REM_W-1:0]  div_rem;
   logic [DIV_NUM_W-1:0]  div_num;
   logic [DIV_REM_W-1:0]  div_dvs;
   logic [DIV_STEP_W-1:0] div_steps;
   logic [DIV_NUM_W-1:0]  div_quo;
   logic                  div_done;

   // Accumulator update and pointer arithmetic.
   always_comb begin
      acc_sum  = {1'b0, acc_ff} + {1'b0, req_delta_time};
      acc_sat  = acc_sum[TIME_W] ? '1 : acc_sum[TIME_W-1:0];
      push     = cmd.take && (req_spawned_count != '0);
      head_dec = (head_ff == '0) ? LAST_IDX : head_ff - PW'(1);
      head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + PW'(1);
      ptr_inc  = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + PW'(1);
      ivl_sel  = (k_ff == '0) ? acc_ff : ivl_rd_ff;
      vol_prod = rate_ff * life_ff;
   end

   // Next state of the history bookkeeping on an accepted item.
   always_comb begin
      held_in = held_ff;
      head_in = head_ff;
      acc_in  = acc_ff;
      if (cmd.take) begin
         if (push) begin
            head_in = head_dec;
            held_in = (held_ff == FULL) ? held_ff : held_ff + HW'(1);
            acc_in  = '0;
         end else begin
            acc_in  = acc_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         head_ff      <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
         head_ff <= head_in;
         acc_ff  <= acc_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // The closed interval goes to the old front, the new sample in front of it.
   always_ff @(posedge clock) begin
      if (push) begin
         ivl_mem[head_ff] <= acc_sat;
         cl_mem[head_dec] <= {req_spawned_count, req_lifetime_total};
      end
      ivl_rd_ff <= ivl_mem[ptr_ff];
      cl_rd_ff  <= cl_mem[ptr_ff];
   end

   // Divider operands for each operation.
   always_comb begin
      div_rem   = '0;
      div_num   = '0;
      div_dvs   = '0;
      div_steps = DIV_STEP_W'(1);
      case (cmd.div_op)
         DIV_MEAN: begin
            div_num   = {sum_ff, {(DIV_NUM_W-SUM_W){1'b0}}};
            div_dvs   = DIV_REM_W'(held_ff - HW'(1));
            div_steps = DIV_STEP_W'(SUM_W);
         end
         DIV_WGT: begin
            div_num   = {1'b1, {(DIV_NUM_W-1){1'b0}}};
            div_dvs   = DIV_REM_W'(tsum_ff);
            div_steps = DIV_STEP_W'(WGT_W);
         end
         DIV_PER: begin
            div_num   = {lt_ff, {(DIV_NUM_W-LIFE_W){1'b0}}};
            div_dvs   = DIV_REM_W'(cnt_ff);
            div_steps = DIV_STEP_W'(32);
         end
         DIV_CNT: begin
            div_rem   = DIV_REM_W'(rnum_ff[RNUM_W-1:16]);
            div_num   = {rnum_ff[15:0], 32'd0};
            div_dvs   = wsum_ff;
            div_steps = DIV_STEP_W'(32);
         end
         DIV_LIFE: begin
            div_rem   = dnum_ff[DNUM_W-1:32];
            div_num   = {dnum_ff[31:0], 16'd0};
            div_dvs   = wsum_ff;
            div_steps = DIV_STEP_W'(32);
         end
         DIV_RATE: begin
            div_num   = {c_ff, 16'd0};
            div_dvs   = DIV_REM_W'(mean_ff);
            div_steps = DIV_STEP_W'(DIV_NUM_W);
         end
         default: begin
            div_steps = DIV_STEP_W'(1);
         end
      endcase
   end

   wsre_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .rem_init (div_rem),
      .num      (div_num),
      .divisor  (div_dvs),
      .steps    (div_steps),
      .quo      (div_quo),
      .done     (div_done)
   );

   // Sweeps over the history and the weighted sums.
   always_ff @(posedge clock) begin
      if (cmd.sum_init) begin
         sum_ff <= '0;
         k_ff   <= HW'(1);
         ptr_ff <= head_inc;
      end else if (cmd.sum_step) begin
         sum_ff <= sum_ff + SUM_W'(ivl_rd_ff);
         k_ff   <= k_ff + HW'(1);
         ptr_ff <= ptr_inc;
      end else if (cmd.walk_init) begin
         tsum_ff <= '0;
         wsum_ff <= '0;
         rnum_ff <= '0;
         lhi_ff  <= '0;
         llo_ff  <= '0;
         if (acc_ff > mean_ff) begin
            k_ff   <= '0;
            ptr_ff <= head_ff;
         end else begin
            k_ff   <= HW'(1);
            ptr_ff <= head_inc;
         end
      end else if (cmd.acc_step) begin
         wsum_ff <= wsum_ff + WSUM_W'(w_ff);
         rnum_ff <= rnum_ff + RNUM_W'(prod_r_ff);
         lhi_ff  <= lhi_ff + RNUM_W'(prod_h_ff);
         llo_ff  <= llo_ff + RNUM_W'(prod_l_ff);
         k_ff    <= k_ff + HW'(1);
         ptr_ff  <= ptr_inc;
      end
      if (cmd.tsum_step) begin
         tsum_ff <= tsum_ff + SUM_W'(ivl_sel);
         cnt_ff  <= cl_rd_ff[COUNT_W+LIFE_W-1:LIFE_W];
         lt_ff   <= cl_rd_ff[LIFE_W-1:0];
      end
      if (cmd.mul) begin
         prod_r_ff <= w_ff * cnt_ff;
         prod_h_ff <= w_ff * per_ff[31:16];
         prod_l_ff <= w_ff * per_ff[15:0];
      end
      if (cmd.ladd) begin
         dnum_ff <= DNUM_W'({lhi_ff, 16'd0}) + DNUM_W'(llo_ff);
      end
   end

   // Quotient capture and results; an accepted item clears the results.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         rate_ff <= '0;
         life_ff <= '0;
         vol_ff  <= '0;
      end else if (cmd.vol) begin
         vol_ff <= vol_prod[2*OUT_W-1:OUT_W];
      end else if (cmd.div_load) begin
         case (cmd.div_op)
            DIV_MEAN: mean_ff <= div_quo[MEAN_W-1:0];
            DIV_WGT:  w_ff    <= (tsum_ff == '0) ? '0 : div_quo[WGT_W-1:0];
            DIV_PER:  per_ff  <= div_quo[LIFE_W-1:0];
            DIV_CNT:  c_ff    <= div_quo[OUT_W-1:0];
            DIV_LIFE: life_ff <= (div_quo[DIV_NUM_W-1:OUT_W] != '0) ? '1 :
                                 div_quo[OUT_W-1:0];
            DIV_RATE: rate_ff <= ((mean_ff == '0) ||
                                  (div_quo[DIV_NUM_W-1:OUT_W] != '0)) ? '1 :
                                 div_quo[OUT_W-1:0];
            default:  mean_ff <= mean_ff;
         endcase
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_rate_ff <= rate_ff;
         out_life_ff <= life_ff;
         out_vol_ff  <= vol_ff;
      end
   end

   always_comb begin
      status.held_lt2  = (held_ff < HW'(2));
      status.k_last    = (k_ff == held_ff - HW'(1));
      status.div_done  = div_done;
      status.wsum_zero = (wsum_ff == '0);
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_rate_estimate   = out_rate_ff;
   assign rsp_life_estimate   = out_life_ff;
   assign rsp_volume_estimate = out_vol_ff;

   // The sample count never passes the history depth.
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      held_ff <= FULL) else $error("sample count beyond history depth");

   // A result is loaded only when the output register can take it.
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready)) else $error("result overwritten");

endmodule

/* hdl/wsre_ctrl.sv */
// Controller state machine that sequences the estimator datapath.
// Depends on wsre_pkg for the command and status types.
module wsre_ctrl
   import wsre_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_SINIT = 5'd1;
   localparam logic [4:0] S_SRD   = 5'd2;
   localparam logic [4:0] S_SACC  = 5'd3;
   localparam logic [4:0] S_MGO   = 5'd4;
   localparam logic [4:0] S_MWAIT = 5'd5;
   localparam logic [4:0] S_WINIT = 5'd6;
   localparam logic [4:0] S_WRD   = 5'd7;
   localparam logic [4:0] S_WT    = 5'd8;
   localparam logic [4:0] S_WGO   = 5'd9;
   localparam logic [4:0] S_WWAIT = 5'd10;
   localparam logic [4:0] S_PGO   = 5'd11;
   localparam logic [4:0] S_PWAIT = 5'd12;
   localparam logic [4:0] S_MUL   = 5'd13;
   localparam logic [4:0] S_WACC  = 5'd14;
   localparam logic [4:0] S_CHK   = 5'd15;
   localparam logic [4:0] S_CGO   = 5'd16;
   localparam logic [4:0] S_CWAIT = 5'd17;
   localparam logic [4:0] S_LADD  = 5'd18;
   localparam logic [4:0] S_LGO   = 5'd19;
   localparam logic [4:0] S_LWAIT = 5'd20;
   localparam logic [4:0] S_RGO   = 5'd21;
   localparam logic [4:0] S_RWAIT = 5'd22;
   localparam logic [4:0] S_VOL   = 5'd23;
   localparam logic [4:0] S_FIN   = 5'd24;

   logic [4:0] state_ff, state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_SINIT;
            end
         end
         S_SINIT: begin
            if (status.held_lt2) begin
               state_in = S_FIN;
            end else begin
               cmd.sum_init = 1'b1;
               state_in     = S_SRD;
            end
         end
         S_SRD: state_in = S_SACC;
         S_SACC: begin
            cmd.sum_step = 1'b1;
            state_in     = status.k_last ? S_MGO : S_SRD;
         end
         S_MGO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_MEAN;
            state_in      = S_MWAIT;
         end
         S_MWAIT: begin
            cmd.div_op = DIV_MEAN;
            if (status.div_done) begin
               cmd.div_load = 1'b1;
               state_in     = S_WINIT;
            end
         end
         S_WINIT: begin
            cmd.walk_init = 1'b1;
            state_in      = S_WRD;
         end
         S_WRD: state_in = S_WT;
         S_WT: begin
            cmd.tsum_step = 1'b1;
            state_in      = S_WGO;
         end
         S_WGO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_WGT;
            state_in      = S_WWAIT;
         end
         S_WWAIT: begin
            cmd.div_op = DIV_WGT;
            if (status.div_done) begin
               cmd.div_load = 1'b1;
               state_in     = S_PGO;
            end
         end
         S_PGO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_PER;
            state_in      = S_PWAIT;
         end
         S_PWAIT: begin
            cmd.div_op = DIV_PER;
            if (status.div_done) begin
               cmd.div_load = 1'b1;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_WACC;
         end
         S_WACC: begin
            cmd.acc_step = 1'b1;
            state_in     = status.k_last ? S_CHK : S_WRD;
         end
         S_CHK: state_in = status.wsum_zero ? S_FIN : S_CGO;
         S_CGO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_CNT;
            state_in      = S_CWAIT;
         end
         S_CWAIT: begin
            cmd.div_op = DIV_CNT;
            if (status.div_done) begin
               cmd.div_load = 1'b1;
               state_in     = S_LADD;
            end
         end
         S_LADD: begin
            cmd.ladd = 1'b1;
            state_in = S_LGO;
         end
         S_LGO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_LIFE;
            state_in      = S_LWAIT;
         end
         S_LWAIT: begin
            cmd.div_op = DIV_LIFE;
            if (status.div_done) begin
               cmd.div_load = 1'b1;
               state_in     = S_RGO;
            end
         end
         S_RGO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_RATE;
            state_in      = S_RWAIT;
         end
         S_RWAIT: begin
            cmd.div_op = DIV_RATE;
            if (status.div_done) begin
               cmd.div_load = 1'b1;
               state_in     = S_VOL;
            end
         end
         S_VOL: begin
            cmd.vol  = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

/* hdl/weighted_spawn_rate_estimator.sv */
// Top level of the weighted spawn rate estimator: controller plus datapath.
// Depends on wsre_pkg, wsre_ctrl and wsre_dp.
//
// One tick is taken at a time and gives one result. A tick holds the block
// until its result is loaded into the output register, which waits while
// that register holds a result not yet taken. The weight walk covers all
// stored samples or all but one. With fewer than two samples no division runs.
// When every weight is zero the last three divisions are skipped.
// The single shared divider produces one quotient bit per cycle and runs two
// divisions for every walked sample plus four per tick. The result sits in an
// output register, so the next tick may be transferred while the previous
// result still waits. History entries hold no reset values; the sample count
// alone decides which are read.
module weighted_spawn_rate_estimator
   import wsre_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [TIME_W-1:0]  req_delta_time,
   input  logic [COUNT_W-1:0] req_spawned_count,
   input  logic [LIFE_W-1:0]  req_lifetime_total,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [OUT_W-1:0]   rsp_rate_estimate,
   output logic [OUT_W-1:0]   rsp_life_estimate,
   output logic [OUT_W-1:0]   rsp_volume_estimate
);

   dp_cmd_type    cmd;
   dp_status_type status;

   wsre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wsre_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_delta_time      (req_delta_time),
      .req_spawned_count   (req_spawned_count),
      .req_lifetime_total  (req_lifetime_total),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_rate_estimate   (rsp_rate_estimate),
      .rsp_life_estimate   (rsp_life_estimate),
      .rsp_volume_estimate (rsp_volume_estimate)
   );

endmodule
